FILE: rtl/core/waveform_column_averager_defines.svh
// assertion macros for the waveform column averager
`ifndef WAVEFORM_COLUMN_AVERAGER_DEFINES_SVH
`define WAVEFORM_COLUMN_AVERAGER_DEFINES_SVH

// condition and consequence in the same cycle
`define WCA_ASSERT_NOW(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("wca assertion failed");

// consequence in the cycle after the condition
`define WCA_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("wca assertion failed");

`endif

FILE: rtl/core/wca_pkg.sv
// types and constants shared by the waveform column averager
package wca_pkg;

	localparam int COUNT_BITS = 16;
	localparam int SAMPLE_BITS = 24;
	localparam int STEP_W = 24;
	localparam int HEIGHT_W = 16;
	localparam int POS_W = 32;
	localparam int SUM_W = SAMPLE_BITS + COUNT_BITS;
	localparam int DVD_W = SUM_W + 1;
	localparam int DVS_W = COUNT_BITS + 1;
	localparam int STEP_CNT_W = $clog2(DVD_W);
	localparam int BASE_W = HEIGHT_W + 8;
	localparam int Y_W = ((SAMPLE_BITS > BASE_W) ? SAMPLE_BITS : BASE_W) + 2;
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int REG_IDX_W = 1;
	localparam int CFG_DATA_W = STEP_W;

	localparam logic [REG_IDX_W-1:0] REG_PIXELS_PER_SAMPLE = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_PLOT_HEIGHT = REG_IDX_W'(1);

	localparam logic [STEP_W-1:0] STEP_RESET = 24'h01_0000;
	localparam logic [POS_W-1:0] ONE_Q16 = 32'h0001_0000;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic signed [Y_W-1:0] Y_MAX = Y_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [Y_W-1:0] Y_MIN = Y_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

	typedef struct packed {
		logic [POS_W-1:0] point_x;
		logic signed [SUM_W-1:0] sum;
		logic [COUNT_BITS-1:0] count;
		logic [HEIGHT_W-1:0] height;
	} col_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

FILE: rtl/core/wca_if.sv
// sample and point channel interfaces
interface wca_sample_if import wca_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [SAMPLE_BITS-1:0] sample_value;
	logic first_sample;

	modport source (output valid, output sample_value, output first_sample, input ready);
	modport sink (input valid, input sample_value, input first_sample, output ready);
endinterface

interface wca_point_if import wca_pkg::*; ();
	logic valid;
	logic ready;
	logic [POS_W-1:0] point_x;
	logic signed [SAMPLE_BITS-1:0] point_y;

	modport source (output valid, output point_x, output point_y, input ready);
	modport sink (input valid, input point_x, input point_y, output ready);
endinterface

FILE: rtl/core/wca_front.sv
// front end: config registers, phase and column accumulation
module wca_front import wca_pkg::*; (
	input logic clk,
	input logic arst_n,
	wca_sample_if.sink sample_ch,
	input logic wr_en,
	input logic [REG_IDX_W-1:0] wr_index,
	input logic [CFG_DATA_W-1:0] wr_data,
	input q_stat_t q_stat,
	output logic push,
	output col_t push_col
);

	logic [STEP_W-1:0] step_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [POS_W-1:0] phase_q;
	logic [POS_W-1:0] x_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [COUNT_BITS-1:0] count_q;

	logic accept;
	logic emit;
	logic [POS_W-1:0] phase_base;
	logic [POS_W-1:0] x_base;
	logic signed [SUM_W-1:0] sum_base;
	logic [COUNT_BITS-1:0] count_base;
	logic [POS_W:0] phase_sum;
	logic [POS_W:0] x_sum;
	logic [POS_W-1:0] phase_new;
	logic [POS_W-1:0] x_new;
	logic signed [SUM_W-1:0] sum_new;
	logic [COUNT_BITS-1:0] count_new;

	assign sample_ch.ready = !q_stat.full;

	always_comb begin
		accept = sample_ch.valid && sample_ch.ready;
		phase_base = sample_ch.first_sample ? '0 : phase_q;
		x_base = sample_ch.first_sample ? '0 : x_q;
		sum_base = sample_ch.first_sample ? '0 : sum_q;
		count_base = sample_ch.first_sample ? '0 : count_q;
		phase_sum = {1'b0, phase_base} + (POS_W + 1)'(step_q);
		x_sum = {1'b0, x_base} + (POS_W + 1)'(step_q);
		phase_new = phase_sum[POS_W] ? '1 : phase_sum[POS_W-1:0];
		x_new = x_sum[POS_W] ? '1 : x_sum[POS_W-1:0];
		sum_new = sum_base;
		count_new = count_base;
		if (count_base != COUNT_MAX) begin
			count_new = count_base + COUNT_BITS'(1);
			sum_new = sum_base + SUM_W'(sample_ch.sample_value);
		end
		emit = phase_new > ONE_Q16;
		push = accept && emit;
		push_col.point_x = x_base;
		push_col.sum = sum_new;
		push_col.count = count_new;
		push_col.height = height_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
			height_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_PIXELS_PER_SAMPLE: step_q <= wr_data[STEP_W-1:0];
				REG_PLOT_HEIGHT: height_q <= wr_data[HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			x_q <= '0;
			sum_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			phase_q <= emit ? phase_new - ONE_Q16 : phase_new;
			sum_q <= emit ? '0 : sum_new;
			count_q <= emit ? '0 : count_new;
			x_q <= x_new;
		end
	end

endmodule

FILE: rtl/core/wca_queue.sv
// small fifo of finished columns between front and back end
module wca_queue import wca_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input col_t push_col,
	input logic pop,
	output col_t head_col,
	output q_stat_t q_stat
);

	col_t mem [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_PTR_W:0] fill_q;
	logic do_push;
	logic do_pop;

	always_comb begin
		q_stat.full = fill_q == (Q_PTR_W + 1)'(Q_DEPTH);
		q_stat.empty = fill_q == '0;
		do_push = push && !q_stat.full;
		do_pop = pop && !q_stat.empty;
		head_col = mem[rd_ptr_q];
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_col;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + (Q_PTR_W + 1)'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - (Q_PTR_W + 1)'(1);
			end
		end
	end

endmodule

FILE: rtl/core/wca_back.sv
// back end: bit-serial rounded mean divider and point output register
`include "waveform_column_averager_defines.svh"

module wca_back import wca_pkg::*; (
	input logic clk,
	input logic arst_n,
	input col_t head_col,
	input q_stat_t q_stat,
	output logic pop,
	wca_point_if.source point_ch
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV = 3'b010,
		ST_FIN = 3'b100
	} state_t;

	state_t state_q;
	logic [STEP_CNT_W-1:0] step_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic neg_q;
	logic [POS_W-1:0] x_q;
	logic [BASE_W-1:0] base_q;

	logic out_valid_q;
	logic [POS_W-1:0] out_x_q;
	logic signed [SAMPLE_BITS-1:0] out_y_q;

	logic sum_neg;
	logic [DVD_W-1:0] dvd_init;
	logic [DVS_W:0] rem_sh;
	logic [DVS_W:0] rem_diff;
	logic q_bit;
	logic signed [Y_W-1:0] y_base;
	logic signed [Y_W-1:0] y_mean;
	logic signed [Y_W-1:0] y_raw;
	logic signed [SAMPLE_BITS-1:0] y_sat;
	logic out_free;
	logic load_out;

	always_comb begin
		pop = (state_q == ST_IDLE) && !q_stat.empty;
		sum_neg = head_col.sum[SUM_W-1];
		// magnitude times two plus count, negation folded into the add
		if (sum_neg) begin
			dvd_init = {~head_col.sum, 1'b0} + DVD_W'(DVS_W'(head_col.count) + DVS_W'(2));
		end else begin
			dvd_init = {head_col.sum, 1'b0} + DVD_W'(head_col.count);
		end
		rem_sh = {rem_q, dvd_q[DVD_W-1]};
		rem_diff = rem_sh - {1'b0, dvs_q};
		q_bit = rem_sh >= {1'b0, dvs_q};
		y_base = Y_W'({base_q});
		y_mean = Y_W'(dvd_q[SAMPLE_BITS-1:0]);
		y_raw = neg_q ? y_base + y_mean : y_base - y_mean;
		if (y_raw > Y_MAX) begin
			y_sat = Y_MAX[SAMPLE_BITS-1:0];
		end else if (y_raw < Y_MIN) begin
			y_sat = Y_MIN[SAMPLE_BITS-1:0];
		end else begin
			y_sat = y_raw[SAMPLE_BITS-1:0];
		end
		out_free = !out_valid_q || point_ch.ready;
		load_out = (state_q == ST_FIN) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_DIV;
						step_q <= '0;
					end
				end
				ST_DIV: begin
					if (step_q == STEP_CNT_W'(DVD_W - 1)) begin
						state_q <= ST_FIN;
					end else begin
						step_q <= step_q + STEP_CNT_W'(1);
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			dvd_q <= dvd_init;
			dvs_q <= {head_col.count, 1'b0};
			rem_q <= '0;
			neg_q <= sum_neg;
			x_q <= head_col.point_x;
			base_q <= {head_col.height, 8'h00};
		end else if (state_q == ST_DIV) begin
			dvd_q <= {dvd_q[DVD_W-2:0], q_bit};
			rem_q <= q_bit ? rem_diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (point_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_x_q <= x_q;
			out_y_q <= y_sat;
		end
	end

	assign point_ch.valid = out_valid_q;
	assign point_ch.point_x = out_x_q;
	assign point_ch.point_y = out_y_q;

	`WCA_ASSERT_NOW(a_pop_only_idle, clk, arst_n, pop, state_q == ST_IDLE && !q_stat.empty)
	`WCA_ASSERT_NOW(a_step_range, clk, arst_n, state_q == ST_DIV, step_q <= STEP_CNT_W'(DVD_W - 1))
	`WCA_ASSERT_NEXT(a_div_done, clk, arst_n, state_q == ST_DIV && step_q == STEP_CNT_W'(DVD_W - 1), state_q == ST_FIN)
	`WCA_ASSERT_NEXT(a_fin_loads, clk, arst_n, load_out, out_valid_q && out_x_q == $past(x_q))

endmodule

FILE: rtl/core/waveform_column_averager.sv
// top level of the waveform column averager
//
// channel      dir  payload                        request
// sample_ch    in   sample_value, first_sample     one amplitude sample
// point_ch     out  point_x, point_y               one plot point
//
// the front end takes one sample per cycle while the column queue has room
// the back end takes one column at a time through its idle, divide and finish states
// the queue holds four finished columns, sample_ch.ready drops when it is full
// a finished point waits in the output register while the divider starts the next one
// reset is asynchronous and clears all control state, there is no clearing pass
module waveform_column_averager import wca_pkg::*; (
	input logic clk,
	input logic arst_n,
	wca_sample_if.sink sample_ch,
	wca_point_if.source point_ch,
	input logic wr_en,
	input logic [REG_IDX_W-1:0] wr_index,
	input logic [CFG_DATA_W-1:0] wr_data
);

	logic push;
	col_t push_col;
	logic pop;
	col_t head_col;
	q_stat_t q_stat;

	wca_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.sample_ch(sample_ch),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.q_stat(q_stat),
		.push(push),
		.push_col(push_col)
	);

	wca_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_col(push_col),
		.pop(pop),
		.head_col(head_col),
		.q_stat(q_stat)
	);

	wca_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_col(head_col),
		.q_stat(q_stat),
		.pop(pop),
		.point_ch(point_ch)
	);

endmodule
